### design/hcbd_pkg.sv
// Shared types, codes and helpers for the chunked body decoder.
package hcbd_pkg;

    localparam logic [7:0]  CharCr   = 8'h0D;
    localparam logic [7:0]  CharLf   = 8'h0A;
    localparam logic [31:0] MaxChunk = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_EXT      = 4'd1,
        PH_SIZE_LF  = 4'd2,
        PH_DATA     = 4'd3,
        PH_DROP1    = 4'd4,
        PH_DROP2    = 4'd5,
        PH_TAIL_CR  = 4'd6,
        PH_TAIL_LF  = 4'd7,
        PH_FINISHED = 4'd8,
        PH_FAILED   = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] chunk_size_accum;
        logic        digit_seen;
        logic [30:0] bytes_left;
        logic [31:0] length_total;
    } t_dec_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  body_byte;
        logic [31:0] total_len;
    } t_result;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

### design/hcbd_step.sv
// Next-state and result logic for one body byte.
module hcbd_step (
    input  hcbd_pkg::t_dec_state i_state,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_new_message,
    output hcbd_pkg::t_dec_state o_state,
    output logic                 o_res_valid,
    output hcbd_pkg::t_result    o_res
);

    hcbd_pkg::t_dec_state cur;
    logic [4:0]           hex;
    logic [35:0]          size_next;
    logic [32:0]          len_sum;
    logic [30:0]          left_dec;

    always_comb begin
        cur = i_state;
        if (i_new_message) begin
            cur.phase            = hcbd_pkg::PH_SIZE;
            cur.chunk_size_accum = 32'd0;
            cur.digit_seen       = 1'b0;
            cur.bytes_left       = 31'd0;
            cur.length_total     = 32'd0;
        end
    end

    assign hex       = hcbd_pkg::hex_decode(i_data_byte);
    assign size_next = {cur.chunk_size_accum, 4'd0} + {32'd0, hex[3:0]};
    assign len_sum   = {1'b0, cur.length_total} + {1'b0, cur.chunk_size_accum};
    assign left_dec  = cur.bytes_left - 31'd1;

    always_comb begin
        o_state = cur;
        unique case (cur.phase)
            hcbd_pkg::PH_SIZE: begin
                if (hex[4]) begin
                    if (size_next > {4'd0, hcbd_pkg::MaxChunk}) begin
                        o_state.phase = hcbd_pkg::PH_FAILED;
                    end else begin
                        o_state.chunk_size_accum = size_next[31:0];
                        o_state.digit_seen       = 1'b1;
                    end
                end else if (!cur.digit_seen) begin
                    o_state.phase = hcbd_pkg::PH_FAILED;
                end else if (i_data_byte == hcbd_pkg::CharCr) begin
                    o_state.phase = hcbd_pkg::PH_SIZE_LF;
                end else begin
                    o_state.phase = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (i_data_byte == hcbd_pkg::CharCr) begin
                    o_state.phase = hcbd_pkg::PH_SIZE_LF;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                if (i_data_byte != hcbd_pkg::CharLf) begin
                    o_state.phase = hcbd_pkg::PH_FAILED;
                end else if (cur.chunk_size_accum == 32'd0) begin
                    o_state.phase = hcbd_pkg::PH_TAIL_CR;
                end else if (len_sum[32]) begin
                    o_state.length_total = 32'hFFFF_FFFF;
                    o_state.phase        = hcbd_pkg::PH_FAILED;
                end else begin
                    o_state.length_total = len_sum[31:0];
                    o_state.bytes_left   = cur.chunk_size_accum[30:0];
                    o_state.phase        = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA: begin
                o_state.bytes_left = left_dec;
                if (left_dec == 31'd0) begin
                    o_state.phase = hcbd_pkg::PH_DROP1;
                end
            end
            hcbd_pkg::PH_DROP1: begin
                o_state.phase = hcbd_pkg::PH_DROP2;
            end
            hcbd_pkg::PH_DROP2: begin
                o_state.phase            = hcbd_pkg::PH_SIZE;
                o_state.chunk_size_accum = 32'd0;
                o_state.digit_seen       = 1'b0;
            end
            hcbd_pkg::PH_TAIL_CR: begin
                if (i_data_byte != hcbd_pkg::CharCr) begin
                    o_state.phase = hcbd_pkg::PH_FAILED;
                end else begin
                    o_state.phase = hcbd_pkg::PH_TAIL_LF;
                end
            end
            hcbd_pkg::PH_TAIL_LF: begin
                if (i_data_byte != hcbd_pkg::CharLf) begin
                    o_state.phase = hcbd_pkg::PH_FAILED;
                end else begin
                    o_state.phase = hcbd_pkg::PH_FINISHED;
                end
            end
            default: begin
                o_state = cur;
            end
        endcase
    end

    // An error result comes from exactly the conditions that park the parser in PH_FAILED.
    always_comb begin
        o_res_valid     = 1'b0;
        o_res.kind      = hcbd_pkg::KIND_ERROR;
        o_res.body_byte = 8'd0;
        unique case (cur.phase)
            hcbd_pkg::PH_SIZE: begin
                if (hex[4]) begin
                    o_res_valid = size_next > {4'd0, hcbd_pkg::MaxChunk};
                end else begin
                    o_res_valid = !cur.digit_seen;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                o_res_valid = (i_data_byte != hcbd_pkg::CharLf) ||
                              ((cur.chunk_size_accum != 32'd0) && len_sum[32]);
            end
            hcbd_pkg::PH_DATA: begin
                o_res_valid     = 1'b1;
                o_res.kind      = hcbd_pkg::KIND_DATA;
                o_res.body_byte = i_data_byte;
            end
            hcbd_pkg::PH_TAIL_CR: begin
                o_res_valid = (i_data_byte != hcbd_pkg::CharCr);
            end
            hcbd_pkg::PH_TAIL_LF: begin
                o_res_valid = 1'b1;
                if (i_data_byte == hcbd_pkg::CharLf) begin
                    o_res.kind = hcbd_pkg::KIND_DONE;
                end
            end
            default: begin
            end
        endcase
        o_res.total_len = o_state.length_total;
    end

endmodule

### design/hcbd_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module hcbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcbd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output hcbd_pkg::t_result o_res
);

    logic              r_valid;
    logic              n_valid;
    hcbd_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/http_chunked_body_decoder.sv
// Top level of the HTTP chunked transfer body decoder.
// A result is registered: it appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the decoder state updates in the accepting cycle.
// The only stall comes from the result register being full and not drained.
// Reset (synchronous, active low) clears the parse state and drops any held result.
module http_chunked_body_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_total_len
);

    // Decoder state: the phase of the framing parser, the size being read,
    // the data bytes still owed by the current chunk and the running length.
    hcbd_pkg::t_dec_state r_state;
    hcbd_pkg::t_dec_state n_state;
    logic                 step_res_valid;
    hcbd_pkg::t_result    step_res;
    hcbd_pkg::t_result    out_res;
    logic                 out_free;
    logic                 accept;

    // A byte is taken whenever the result register can take a result, so a
    // new byte enters while the previous result is being handed off.
    assign o_ready = out_free;
    assign accept  = i_valid && out_free;

    hcbd_step u_step (
        .i_state       (r_state),
        .i_data_byte   (i_data_byte),
        .i_new_message (i_new_message),
        .o_state       (n_state),
        .o_res_valid   (step_res_valid),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= hcbd_pkg::PH_SIZE;
            r_state.chunk_size_accum <= 32'd0;
            r_state.digit_seen       <= 1'b0;
            r_state.bytes_left       <= 31'd0;
            r_state.length_total     <= 32'd0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Framing bytes produce no result unless they end the body or break the format, so only
    // bytes that yield one load the output register.
    hcbd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && step_res_valid),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_kind      = out_res.kind;
    assign o_body_byte = out_res.body_byte;
    assign o_total_len = out_res.total_len;

endmodule

### tb/sv/http_chunked_body_decoder_tb.sv
// Self-checking testbench for the HTTP chunked body decoder.
module http_chunked_body_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    // The run is stopped by the watchdog if it goes on far longer than any correct run could.
    localparam int CycleLimit = 200000;
    // The number of random items that is aimed for after the directed part.
    localparam int RandomItems = 600;

    // This class tracks the decoder state item by item. It also holds the results that the
    // decoder still owes, oldest first, and it compares what comes out against them.
    class chunked_tracker;
        t_phase      phase;
        logic [31:0] size_acc;
        logic        got_digit;
        logic [30:0] left;
        logic [31:0] total;
        t_result     owed_q[$];
        int          errors;
        int          n_items;
        int          n_data;
        int          n_done;
        int          n_fail;

        function new();
            errors  = 0;
            n_items = 0;
            n_data  = 0;
            n_done  = 0;
            n_fail  = 0;
            owed_q  = {};
            restart();
        endfunction

        function void restart();
            phase     = PH_SIZE;
            size_acc  = '0;
            got_digit = 1'b0;
            left      = '0;
            total     = '0;
        endfunction

        function void owe(t_kind kind, logic [7:0] b);
            t_result r;
            r.kind      = kind;
            r.body_byte = b;
            r.total_len = total;
            owed_q.push_back(r);
        endfunction

        // A format error also parks the decoder until the next new message.
        function void format_error();
            phase = PH_FAILED;
            n_fail++;
            owe(KIND_ERROR, 8'h00);
        endfunction

        // Returns 1 and the digit value for 0-9, A-F and a-f.
        function bit digit_value(input logic [7:0] c, output logic [3:0] v);
            v = 4'h0;
            if (c >= "0" && c <= "9") begin
                v = 4'(c - "0");
                return 1'b1;
            end
            if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") begin
                v = 4'((c | 8'h20) - "a" + 10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advances the tracked state by one accepted item.
        function void take_byte(input logic [7:0] c, input logic nm);
            logic [3:0]  v;
            logic [35:0] grown;
            logic [32:0] sum;
            n_items++;
            if (nm) begin
                restart();
            end
            case (phase)
                PH_SIZE: begin
                    if (digit_value(c, v)) begin
                        grown = {size_acc, 4'h0} + 36'(v);
                        if (grown > 36'(MaxChunk)) begin
                            format_error();
                        end else begin
                            size_acc  = grown[31:0];
                            got_digit = 1'b1;
                        end
                    end else if (!got_digit) begin
                        format_error();
                    end else begin
                        phase = (c == CharCr) ? PH_SIZE_LF : PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (c == CharCr) begin
                        phase = PH_SIZE_LF;
                    end
                end
                PH_SIZE_LF: begin
                    if (c != CharLf) begin
                        format_error();
                    end else if (size_acc == 32'd0) begin
                        phase = PH_TAIL_CR;
                    end else begin
                        sum = {1'b0, total} + {1'b0, size_acc};
                        if (sum[32]) begin
                            total = '1;
                            format_error();
                        end else begin
                            total = sum[31:0];
                            left  = size_acc[30:0];
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    left = left - 31'd1;
                    if (left == 31'd0) begin
                        phase = PH_DROP1;
                    end
                    n_data++;
                    owe(KIND_DATA, c);
                end
                PH_DROP1: begin
                    phase = PH_DROP2;
                end
                PH_DROP2: begin
                    phase     = PH_SIZE;
                    size_acc  = '0;
                    got_digit = 1'b0;
                end
                PH_TAIL_CR: begin
                    if (c != CharCr) begin
                        format_error();
                    end else begin
                        phase = PH_TAIL_LF;
                    end
                end
                PH_TAIL_LF: begin
                    if (c != CharLf) begin
                        format_error();
                    end else begin
                        phase = PH_FINISHED;
                        n_done++;
                        owe(KIND_DONE, 8'h00);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest result still owed.
        function void check_output(input logic [1:0] kind, input logic [7:0] b,
                                   input logic [31:0] len);
            t_result w;
            if (owed_q.size() == 0) begin
                $display("%0t: result expected none actual kind %0d byte %h length %h",
                         $time, kind, b, len);
                errors++;
                return;
            end
            w = owed_q.pop_front();
            if (kind !== w.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
                errors++;
            end
            if (b !== w.body_byte) begin
                $display("%0t: body_byte expected %h actual %h", $time, w.body_byte, b);
                errors++;
            end
            if (len !== w.total_len) begin
                $display("%0t: total_len expected %h actual %h",
                         $time, w.total_len, len);
                errors++;
            end
        endfunction
    endclass

    // One item for the input channel.
    typedef struct packed {
        logic [7:0] b;
        logic       nm;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_new_message;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_body_byte;
    logic [31:0] o_total_len;

    chunked_tracker tracker = new();
    t_item          item_q[$];
    logic [7:0]     msg_q[$];
    int             cycle_count = 0;
    int             rx_tick = 0;
    int             rx_mode = 0;
    int             rx_hold = 0;

    http_chunked_body_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_new_message (i_new_message),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_body_byte   (o_body_byte),
        .o_total_len   (o_total_len)
    );

    // The clock has a 10 ns period.
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Reset is held low at the start of the run and is never asserted again.
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data_byte   <= 8'h00;
        i_new_message <= 1'b0;
        i_ready       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Appends the bytes of a string as items. Only the first one may start a new message.
    // CR and LF are written as the octal escapes 015 and 012.
    task automatic add_text(input string s, input logic nm_first);
        for (int k = 0; k < s.len(); k++) begin
            item_q.push_back({s[k], (k == 0) ? nm_first : 1'b0});
        end
    endtask

    // Returns the hex digit for a nibble, with letters in a random case.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Writes a size line: optional leading zeros, the digits, an optional extension and CR LF.
    task automatic put_size_line(input int unsigned size);
        logic [7:0]  digits[$];
        int unsigned v;
        int          pad;
        logic [7:0]  e;
        v = size;
        do begin
            digits.push_front(hex_char(4'(v % 16)));
            v = v / 16;
        end while (v != 0);
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) msg_q.push_back("0");
        foreach (digits[k]) msg_q.push_back(digits[k]);
        // An extension is any text up to the CR, so any byte but CR may appear in it.
        if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(";");
            repeat ($urandom_range(0, 4)) begin
                e = 8'($urandom_range(0, 255));
                msg_q.push_back((e == CharCr) ? 8'h78 : e);
            end
        end
        msg_q.push_back(CharCr);
        msg_q.push_back(CharLf);
    endtask

    // Builds one random message, mostly well formed, and appends it as items.
    task automatic add_message();
        int          n_chunks;
        int unsigned size;
        int          cut;
        msg_q    = {};
        n_chunks = $urandom_range(0, 3);
        repeat (n_chunks) begin
            // Most chunks are short; a few are long enough to span many idle patterns.
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            put_size_line(size);
            repeat (size) msg_q.push_back(8'($urandom_range(0, 255)));
            // The two bytes after the data are dropped, so now and then they are garbage.
            if ($urandom_range(0, 7) == 0) begin
                msg_q.push_back(8'($urandom_range(0, 255)));
                msg_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg_q.push_back(CharCr);
                msg_q.push_back(CharLf);
            end
        end
        put_size_line(0);
        msg_q.push_back(CharCr);
        msg_q.push_back(CharLf);

        // A share of the messages is broken so that the error paths other than length overflow are reached.
        case ($urandom_range(0, 11))
            0, 1: begin
                msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            2: begin
                // The next message then starts in the middle of this one.
                cut   = $urandom_range(1, msg_q.size());
                msg_q = msg_q[0:cut-1];
            end
            3: begin
                // An eight digit size with the top digit at 8 or above is too large.
                msg_q = {};
                msg_q.push_back(hex_char(4'($urandom_range(8, 15))));
                repeat (7) msg_q.push_back(hex_char(4'($urandom_range(0, 15))));
                msg_q.push_back(CharCr);
                msg_q.push_back(CharLf);
            end
            4: begin
                msg_q = {};
                repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase

        foreach (msg_q[k]) item_q.push_back({msg_q[k], (k == 0) ? 1'b1 : 1'b0});
        // Stray bytes after a message are mostly ignored by the decoder.
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) item_q.push_back({8'($urandom_range(0, 255)), 1'b0});
        end
    endtask

    // The directed part comes first, then random messages.
    task automatic build_items();
        int directed;
        // A two byte chunk with an empty extension carries the extreme payload values.
        // Its trailing delimiter is replaced by garbage, which must be dropped unchecked,
        // and the body then completes.
        add_text("2;\015\012", 1'b1);
        item_q.push_back({8'h00, 1'b0});
        item_q.push_back({8'hFF, 1'b0});
        add_text("zz0\015\012\015\012", 1'b0);
        // A size line without any digit.
        add_text("\015", 1'b1);
        // A size that passes the int range on its last digit, in mixed case.
        add_text("fFfFfFfF", 1'b1);
        // A CR in the size line that is not followed by LF.
        add_text("1\015X", 1'b1);
        // A trailer after the zero size line, which is not supported.
        add_text("0\015\012X", 1'b1);
        directed = item_q.size();
        while (item_q.size() < directed + RandomItems) add_message();
    endtask

    // The sender works in bursts of random length separated by random gaps. Valid stays
    // high with the same payload until the item is accepted. Inputs and outputs are sampled
    // right after the rising edge, before any nonblocking update of that edge takes effect.
    initial begin : sender
        int idx;
        int burst;
        int gap;
        build_items();
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        idx = 0;
        while (idx < item_q.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
            while (burst > 0 && idx < item_q.size()) begin
                i_valid       <= 1'b1;
                i_data_byte   <= item_q[idx].b;
                i_new_message <= item_q[idx].nm;
                @(posedge i_clk);
                while (!o_ready) @(posedge i_clk);
                tracker.take_byte(item_q[idx].b, item_q[idx].nm);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Wait for all owed results, then give the decoder time to show a stray one.
        while (tracker.owed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items over %0d cycles: %0d data bytes, %0d completed bodies,",
                 tracker.n_items, cycle_count, tracker.n_data, tracker.n_done);
        $display("and %0d format errors; %0d mismatches seen.", tracker.n_fail, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // The receiver picks its stall pattern anew at regular intervals: always ready, ready but
    // for a regularly repeating drop, ready at random, or ready with occasional long stalls.
    always @(posedge i_clk) begin : receiver
        rx_tick++;
        if (rx_tick % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= (rx_tick % 4) != 0;
            end
            2: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) begin
                        rx_hold = $urandom_range(1, 12);
                    end
                end
            end
        endcase
    end

    // Every accepted result is checked against the oldest owed result.
    always @(posedge i_clk) begin : monitor
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_output(o_kind, o_body_byte, o_total_len);
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timed out with %0d results still owed",
                     $time, tracker.owed_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

### files.f
design/hcbd_pkg.sv
design/hcbd_step.sv
design/hcbd_out_reg.sv
design/http_chunked_body_decoder.sv
tb/sv/http_chunked_body_decoder_tb.sv
